// File: rtl/egsd_pkg.sv
// Package for the Exp-Golomb stream decoder: item types, status codes, queue depths.
// No dependencies.
`default_nettype none

package egsd_pkg;

    localparam int IN_DEPTH  = 2;
    localparam int OUT_DEPTH = 4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic [3:0] nbits;
        logic       eos;
    } in_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/egsd_front.sv
// Front end: accepts stream bytes, clamps the valid-bit count, queues them for the back end.
// Depends on egsd_pkg.
`default_nettype none

module egsd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       stream_byte,
    input  wire logic [3:0]       valid_bits,
    input  wire logic             end_of_stream,
    output logic                  item_valid,
    output egsd_pkg::in_item_t    item,
    input  wire logic             item_pop
);
    import egsd_pkg::*;

    localparam int PW = $clog2(IN_DEPTH);
    localparam int CW = $clog2(IN_DEPTH + 1);

    in_item_t          mem [IN_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push;
    logic              do_pop;
    in_item_t          new_item;

    assign full       = (count_reg == CW'(IN_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    always_comb
    begin
        new_item.stream_byte = stream_byte;
        new_item.nbits       = (valid_bits > 4'd8) ? 4'd8 : valid_bits;
        new_item.eos         = end_of_stream;
    end

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/egsd_back.sv
// Back end: walks the bits of each queued byte, one per cycle while not stalled, and decodes
// ue(v) codes. Holds one result until its last-in-run flag is known. Depends on egsd_pkg.
`default_nettype none

module egsd_back #(
    parameter int MAX_PREFIX = 31
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  egsd_pkg::in_item_t    item,
    output logic                  item_pop,
    output logic                  res_push,
    output egsd_pkg::out_item_t   res_item,
    input  wire logic             res_full
);
    import egsd_pkg::*;

    logic [5:0]  zc_reg, zc_next;
    logic        rs_reg, rs_next;
    logic [4:0]  sl_reg, sl_next;
    logic [31:0] acc_reg, acc_next;
    logic        skip_reg, skip_next;
    logic [2:0]  idx_reg, idx_next;

    logic        pend_valid_reg, pend_valid_next;
    out_item_t   pend_reg, pend_next;

    logic        final_bit;
    logic        cur_bit;
    logic        r_valid;
    logic [31:0] r_value;
    logic [1:0]  r_status;
    logic        step;

    assign final_bit = (item.nbits == 4'd0) || ({1'b0, idx_reg} == item.nbits - 4'd1);
    assign cur_bit   = item.stream_byte[3'd7 - idx_reg];

    always_comb
    begin
        logic [5:0]  zc_inc;
        logic [4:0]  sl_dec;
        logic [31:0] acc_sh;
        zc_inc   = zc_reg + 6'd1;
        sl_dec   = sl_reg - 5'd1;
        acc_sh   = {acc_reg[30:0], cur_bit};
        zc_next   = zc_reg;
        rs_next   = rs_reg;
        sl_next   = sl_reg;
        acc_next  = acc_reg;
        skip_next = skip_reg;
        r_valid   = 1'b0;
        r_value   = '0;
        r_status  = ST_OK;
        if (item.nbits != 4'd0 && !skip_reg)
        begin
            if (rs_reg)
            begin
                acc_next = acc_sh;
                sl_next  = sl_dec;
                if (sl_dec == 5'd0)
                begin
                    r_valid  = 1'b1;
                    r_value  = acc_sh - 32'd1;
                    zc_next  = '0;
                    rs_next  = 1'b0;
                    sl_next  = '0;
                    acc_next = 32'd1;
                end
            end
            else if (!cur_bit)
            begin
                zc_next = zc_inc;
                if (zc_inc > 6'(MAX_PREFIX))
                begin
                    r_valid   = 1'b1;
                    r_status  = ST_OVF;
                    zc_next   = '0;
                    rs_next   = 1'b0;
                    sl_next   = '0;
                    acc_next  = 32'd1;
                    skip_next = 1'b1;
                end
            end
            else if (zc_reg == 6'd0)
            begin
                r_valid = 1'b1;
            end
            else
            begin
                rs_next  = 1'b1;
                sl_next  = zc_reg[4:0];
                acc_next = 32'd1;
            end
        end
        if (final_bit && item.eos)
        begin
            // a bit result always leaves a clear code, so at most one result per step
            if (!skip_next && (zc_next != 6'd0 || rs_next))
            begin
                r_valid  = 1'b1;
                r_value  = '0;
                r_status = ST_TRUNC;
            end
            zc_next   = '0;
            rs_next   = 1'b0;
            sl_next   = '0;
            acc_next  = 32'd1;
            skip_next = 1'b0;
        end
    end

    assign step     = item_valid && !(r_valid && pend_valid_reg && res_full);
    assign item_pop = step && final_bit;
    assign idx_next = final_bit ? 3'd0 : idx_reg + 3'd1;
    assign res_push = pend_valid_reg && !res_full && (pend_reg.last || (step && r_valid));
    assign res_item = pend_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (step && r_valid)
        begin
            pend_valid_next  = 1'b1;
            pend_next.value  = r_value;
            pend_next.status = r_status;
            pend_next.last   = final_bit;
        end
        else if (res_push)
        begin
            pend_valid_next = 1'b0;
        end
        else if (step && final_bit && pend_valid_reg)
        begin
            pend_next.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zc_reg         <= '0;
            rs_reg         <= 1'b0;
            sl_reg         <= '0;
            acc_reg        <= 32'd1;
            skip_reg       <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                zc_reg   <= zc_next;
                rs_reg   <= rs_next;
                sl_reg   <= sl_next;
                acc_reg  <= acc_next;
                skip_reg <= skip_next;
                idx_reg  <= idx_next;
            end
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// File: rtl/egsd_outq.sv
// Result queue between the back end and the result port.
// Depends on egsd_pkg.
`default_nettype none

module egsd_outq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  egsd_pkg::out_item_t   wr_item,
    output logic                  q_full,
    output logic                  empty,
    input  wire logic             pop,
    output egsd_pkg::out_item_t   head
);
    import egsd_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    out_item_t       mem [OUT_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign q_full  = (count_reg == CW'(OUT_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = wr_en && !q_full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/exp_golomb_stream_decoder.sv
// Top level of the unsigned Exp-Golomb stream decoder.
// Depends on egsd_pkg, egsd_front, egsd_back, egsd_outq.
//
// Input queue: drive stream_byte, valid_bits (0..8, above 8 counts as 8) and
// end_of_stream with push; the byte is taken on a clock edge with push high
// and full low. A two-entry byte queue sits in front of the bit walker.
// Result queue: while empty is low, code_value/status/last_in_run show the
// oldest result; pop high on a clock edge takes it. Status 0 is a decoded
// value, 1 a code cut off by end of stream, 2 a prefix overflow (bits are
// then dropped until end of stream). last_in_run marks the final result of
// a byte.
// Throughput: the bit walker consumes one stream bit per cycle while the
// result queue does not stall it; a byte with no bits still takes one
// step, and bytes are walked back to back.
// Output: a result waits in a hold register until the next result of its
// byte (written to the four-entry result queue at that edge) or until the
// byte's last bit sets its last flag; it then goes to the result queue.
// When pop stays low the result queue fills, the walker stops on the next
// result, the byte queue fills and full rises; nothing is lost.
// Reset clears all queues and the decoder state (no code in progress).
`default_nettype none

module exp_golomb_stream_decoder #(
    parameter int MAX_PREFIX = 31
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   stream_byte,
    input  wire logic [3:0]   valid_bits,
    input  wire logic         end_of_stream,
    output logic              empty,
    input  wire logic         pop,
    output logic [31:0]       code_value,
    output logic [1:0]        status,
    output logic              last_in_run
);
    import egsd_pkg::*;

    logic        item_valid;
    in_item_t    item;
    logic        item_pop;
    logic        res_push;
    out_item_t   res_item;
    logic        res_full;
    out_item_t   head;

    egsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .stream_byte   (stream_byte),
        .valid_bits    (valid_bits),
        .end_of_stream (end_of_stream),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    egsd_back #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_push   (res_push),
        .res_item   (res_item),
        .res_full   (res_full)
    );

    egsd_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_item (res_item),
        .q_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign code_value  = head.value;
    assign status      = head.status;
    assign last_in_run = head.last;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid)
        else $error("byte popped from empty queue");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (code_value == 32'd0))
        else $error("nonzero value with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == ST_OK || status == ST_TRUNC || status == ST_OVF))
        else $error("undefined status code");

endmodule

`default_nettype wire
